>>> hw/rtl/vn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
	localparam int unsigned W          = 24;
	localparam int unsigned RAD_W      = 48;
	localparam int unsigned REM_W      = 27;
	localparam int unsigned SQ_STAGES  = 24;
	localparam int unsigned Q_W        = 23;
	localparam int unsigned DIV_STAGES = 23;
	localparam int unsigned DREM_W     = 25;
	localparam int unsigned ADDR_W     = 3;
	// register index sits at paddr[2]
	localparam logic REG_MIN_MAG = 1'b0;
	localparam logic [W-1:0] MIN_MAG_RESET = 24'd1;
endpackage
`default_nettype wire

>>> hw/rtl/vn_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt (
	input  wire logic                      clk,
	input  wire logic                      ce,
	input  wire logic [vn_pkg::RAD_W-1:0]  rad,
	output logic      [vn_pkg::W-1:0]      root
);
	import vn_pkg::*;

	logic [REM_W-1:0] rem_s  [SQ_STAGES+1];
	logic [W-1:0]     root_s [SQ_STAGES+1];
	logic [RAD_W-1:0] rad_s  [SQ_STAGES+1];
	logic [REM_W-1:0] rem_n  [SQ_STAGES];
	logic [W-1:0]     root_n [SQ_STAGES];
	logic [RAD_W-1:0] rad_n  [SQ_STAGES];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;

	// one result bit per stage, restoring form
	always_comb begin
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] t;
		for (int k = 0; k < SQ_STAGES; k++) begin
			r2 = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
			t  = {1'b0, root_s[k], 2'b01};
			if (r2 >= t) begin
				rem_n[k]  = r2 - t;
				root_n[k] = {root_s[k][W-2:0], 1'b1};
			end else begin
				rem_n[k]  = r2;
				root_n[k] = {root_s[k][W-2:0], 1'b0};
			end
			rad_n[k] = {rad_s[k][RAD_W-3:0], 2'b00};
		end
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1]  <= rem_n[k];
				root_s[k+1] <= root_n[k];
				rad_s[k+1]  <= rad_n[k];
			end
		end
	end

	assign root = root_s[SQ_STAGES];
endmodule
`default_nettype wire

>>> hw/rtl/vn_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_div (
	input  wire logic                  clk,
	input  wire logic                  ce,
	input  wire logic [vn_pkg::W-1:0]  num,
	input  wire logic [vn_pkg::W-1:0]  den,
	input  wire logic                  neg,
	output logic      [vn_pkg::W-1:0]  quo
);
	import vn_pkg::*;

	logic [DREM_W-1:0] r_s [DIV_STAGES+1];
	logic [Q_W-1:0]    q_s [DIV_STAGES+1];
	logic [W-1:0]      d_s [DIV_STAGES+1];
	logic              n_s [DIV_STAGES+1];
	logic [DREM_W-1:0] r_n [DIV_STAGES];
	logic [Q_W-1:0]    q_n [DIV_STAGES];
	logic [W:0]        quo_mag;

	assign r_s[0] = {1'b0, num};
	assign q_s[0] = '0;
	assign d_s[0] = den;
	assign n_s[0] = neg;

	// one quotient bit per stage, numerator pre-scaled by 2^22
	always_comb begin
		logic [DREM_W-1:0] diff;
		for (int k = 0; k < DIV_STAGES; k++) begin
			diff = r_s[k] - {1'b0, d_s[k]};
			if (r_s[k] >= {1'b0, d_s[k]}) begin
				r_n[k] = {diff[DREM_W-2:0], 1'b0};
				q_n[k] = {q_s[k][Q_W-2:0], 1'b1};
			end else begin
				r_n[k] = {r_s[k][DREM_W-2:0], 1'b0};
				q_n[k] = {q_s[k][Q_W-2:0], 1'b0};
			end
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (ce) begin
				r_s[k+1] <= r_n[k];
				q_s[k+1] <= q_n[k];
				d_s[k+1] <= d_s[k];
				n_s[k+1] <= n_s[k];
			end
		end
	end

	assign quo_mag = {2'b00, q_s[DIV_STAGES]};
	assign quo = n_s[DIV_STAGES] ? W'(-quo_mag) : quo_mag[W-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/vector3_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// pipeline from input beat to output beat: square, sum, 24 root stages, 23 divide stages,
// output register
// throughput: one vector per cycle; the whole pipeline holds only while the output
// beat is waiting and m_axis_tready is low
// reset: arst_n clears all valid bits and sets min_magnitude to 1
module vector3_normalize (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [vn_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// vec_x [23:0], vec_y [47:24], vec_z [71:48]
	input  wire logic [71:0]                s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// unit_x [23:0], unit_y [47:24], unit_z [71:48], length [95:72]
	output logic      [95:0]                m_axis_tdata,
	// too_small [0]
	output logic                            m_axis_tuser
);
	import vn_pkg::*;

	localparam int unsigned LAT = 2 + SQ_STAGES + DIV_STAGES;

	logic [W-1:0] min_mag_q;
	logic         ce;
	logic [LAT-1:0] vld_q;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= MIN_MAG_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MIN_MAG) begin
			min_mag_q <= pwdata[W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_MIN_MAG) ? {8'h00, min_mag_q} : 32'h0;

	// the whole pipeline moves as one; the output register frees it
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			vld_q         <= {vld_q[LAT-2:0], s_axis_tvalid};
			m_axis_tvalid <= vld_q[LAT-1];
		end
	end

	// lane front end: abs value and sign of each component
	logic signed [W-1:0] comp [3];
	logic [W-1:0]        absv [3];
	logic                sgn  [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			comp[l] = s_axis_tdata[l*W +: W];
			sgn[l]  = comp[l][W-1];
			absv[l] = sgn[l] ? W'(-comp[l]) : comp[l];
		end
	end

	// stage 1: one squarer per lane
	logic [RAD_W-1:0] sq_s1 [3];
	logic [W-1:0]     abs_s1 [3];
	logic             sgn_s1 [3];
	// stage 2: merge the three squares
	logic [RAD_W-1:0] sum_s2;
	logic [W-1:0]     abs_s2 [3];
	logic             sgn_s2 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < 3; l++) begin
				sq_s1[l]  <= absv[l] * absv[l];
				abs_s1[l] <= absv[l];
				sgn_s1[l] <= sgn[l];
				abs_s2[l] <= abs_s1[l];
				sgn_s2[l] <= sgn_s1[l];
			end
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// magnitude
	logic [W-1:0] mag;
	vn_sqrt u_sqrt (
		.clk  (clk),
		.ce   (ce),
		.rad  (sum_s2),
		.root (mag)
	);

	// components wait beside the root pipeline
	logic [W-1:0] abs_dl [SQ_STAGES] [3];
	logic         sgn_dl [SQ_STAGES] [3];
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < 3; l++) begin
				abs_dl[0][l] <= abs_s2[l];
				sgn_dl[0][l] <= sgn_s2[l];
				for (int k = 1; k < SQ_STAGES; k++) begin
					abs_dl[k][l] <= abs_dl[k-1][l];
					sgn_dl[k][l] <= sgn_dl[k-1][l];
				end
			end
		end
	end

	// divider lanes
	logic [W-1:0] quo [3];
	for (genvar l = 0; l < 3; l++) begin : g_lane
		vn_div u_div (
			.clk (clk),
			.ce  (ce),
			.num (abs_dl[SQ_STAGES-1][l]),
			.den (mag),
			.neg (sgn_dl[SQ_STAGES-1][l]),
			.quo (quo[l])
		);
	end

	// magnitude waits beside the dividers
	logic [W-1:0] mag_dl [DIV_STAGES];
	always_ff @(posedge clk) begin
		if (ce) begin
			mag_dl[0] <= mag;
			for (int k = 1; k < DIV_STAGES; k++) begin
				mag_dl[k] <= mag_dl[k-1];
			end
		end
	end

	// merge: threshold check and output register
	logic mag_ok;
	assign mag_ok = (mag_dl[DIV_STAGES-1] > min_mag_q) && (mag_dl[DIV_STAGES-1] != '0);

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata[0  +: W] <= mag_ok ? quo[0] : '0;
			m_axis_tdata[W  +: W] <= mag_ok ? quo[1] : '0;
			m_axis_tdata[2*W +: W] <= mag_ok ? quo[2] : '0;
			m_axis_tdata[3*W +: W] <= mag_dl[DIV_STAGES-1];
			m_axis_tuser           <= !mag_ok;
		end
	end
endmodule
`default_nettype wire
